// ----- rtl/mdp_pkg.sv -----
package mdp_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int VAL_W     = 18;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int TOTAL_W   = 46;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [TOTAL_W-1:0] total_t;
	typedef logic [CNT_W-1:0]          cnt_t;

	// control broadcast along one sorting row
	typedef struct packed {
		logic load;   // insert value into the sorted row
		logic shift;  // move every entry one place toward the head
		val_t value;  // value to insert
	} cell_ctl_t;

endpackage

// ----- rtl/max_dot_product_pairing.sv -----
// Channel  Dir  Fields (lowest bit up)                       Ends on
// s_*      in   tdata: clicks[17:0], price[35:18]; tlast     s_tvalid & s_tready
// m_*      out  tdata: total[45:0]; tuser: overflow          m_tvalid & m_tready
//
// Each pair is sorted into two rows of cells on acceptance; s_tready stays high
// while loading. A pair with tlast starts a drain: the rows shift toward the head
// one entry a cycle through one 18x18 multiplier and a 46-bit accumulator; the
// sum goes to the result register once the rows and the product stage are empty.
// The result register lets the next set load while the result waits; a finished
// sum waits for that register to free. Reset spares only the cells and product.
module max_dot_product_pairing (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // clicks[17:0], price[35:18], zero pad
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // total[45:0], zero pad
	output logic        m_tuser   // overflow
);
	import mdp_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t    state_q;
	cnt_t      count_q;
	logic      dropped_q;
	logic      prod_vld_s1;
	prod_t     prod_s1;
	total_t    acc_q;
	logic      m_tvalid_q;
	total_t    total_q;
	logic      ovf_q;

	logic      accept;
	logic      full;
	logic      shift;
	logic      out_free;
	cell_ctl_t ctl_c;
	cell_ctl_t ctl_p;
	val_t      head_c;
	val_t      head_p;

	assign s_tready = (state_q == ST_LOAD);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(MAX_ITEMS));
	assign shift    = (state_q == ST_DRAIN) && (count_q != '0);
	assign out_free = !m_tvalid_q || m_tready;

	assign ctl_c.load  = accept && !full;
	assign ctl_c.shift = shift;
	assign ctl_c.value = val_t'(s_tdata[17:0]);
	assign ctl_p.load  = accept && !full;
	assign ctl_p.shift = shift;
	assign ctl_p.value = val_t'(s_tdata[35:18]);

	mdp_chain u_clicks (
		.clk   (clk),
		.ctl   (ctl_c),
		.count (count_q),
		.head  (head_c)
	);

	mdp_chain u_price (
		.clk   (clk),
		.ctl   (ctl_p),
		.count (count_q),
		.head  (head_p)
	);

	// multiply the two heads while draining
	always_ff @(posedge clk) begin
		prod_s1 <= head_c * head_p;
	end

	// sequence load, drain and result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			prod_vld_s1 <= 1'b0;
			acc_q       <= '0;
			m_tvalid_q  <= 1'b0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
		end else begin
			// raise valid on a new sum, drop it once the transaction completes
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (prod_vld_s1) begin
				acc_q <= acc_q + TOTAL_W'(prod_s1);
			end
			case (state_q)
				ST_LOAD: begin
					prod_vld_s1 <= 1'b0;
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (s_tlast) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					prod_vld_s1 <= shift;
					if (shift) begin
						count_q <= count_q - CNT_W'(1);
					end else if (!prod_vld_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					prod_vld_s1 <= 1'b0;
					if (out_free) begin
						total_q    <= acc_q;
						ovf_q      <= dropped_q;
						acc_q      <= '0;
						dropped_q  <= 1'b0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, total_q};
	assign m_tuser  = ovf_q;

endmodule

// ----- rtl/mdp_cell.sv -----
module mdp_cell (
	input  logic              clk,
	input  mdp_pkg::cell_ctl_t ctl,
	input  logic              occupied,
	input  logic              prev_take,
	input  mdp_pkg::val_t     prev_data,
	input  mdp_pkg::val_t     next_data,
	output logic              take,
	output mdp_pkg::val_t     data
);
	import mdp_pkg::*;

	val_t data_q;

	// open a slot here when empty or when the new value is strictly larger
	assign take = !occupied || (data_q < ctl.value);
	assign data = data_q;

	// insert: take the neighbor's entry if it moves down, else the new value; shift: take the next entry
	always_ff @(posedge clk) begin
		if (ctl.load && take) begin
			data_q <= prev_take ? prev_data : ctl.value;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

endmodule

// ----- rtl/mdp_chain.sv -----
module mdp_chain (
	input  logic               clk,
	input  mdp_pkg::cell_ctl_t ctl,
	input  mdp_pkg::cnt_t      count,
	output mdp_pkg::val_t      head
);
	import mdp_pkg::*;

	logic [MAX_ITEMS-1:0] take;
	val_t                 data [MAX_ITEMS];

	// one cell per slot, kept in descending order from the head
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic occ;
		logic prev_take;
		val_t prev_data;
		val_t next_data;

		assign occ = CNT_W'(i) < count;

		if (i == 0) begin : g_first
			assign prev_take = 1'b0;
			assign prev_data = ctl.value;
		end else begin : g_inner
			assign prev_take = take[i-1];
			assign prev_data = data[i-1];
		end

		if (i == MAX_ITEMS - 1) begin : g_tail
			assign next_data = data[i];
		end else begin : g_body
			assign next_data = data[i+1];
		end

		mdp_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occ),
			.prev_take (prev_take),
			.prev_data (prev_data),
			.next_data (next_data),
			.take      (take[i]),
			.data      (data[i])
		);
	end

	assign head = data[0];

endmodule
